>>> hw/rtl/vgfc_pkg.sv
package vgfc_pkg;

	typedef logic [2:0] mat_t;

	localparam mat_t MAT_EMPTY   = 3'd0;
	localparam mat_t MAT_BEDROCK = 3'd1;
	localparam mat_t MAT_STONE   = 3'd2;
	localparam mat_t MAT_DIRT    = 3'd3;
	localparam mat_t MAT_GRASS   = 3'd4;

	typedef logic [1:0] act_t;

	localparam act_t ACT_QUERY   = 2'd0;
	localparam act_t ACT_PLACE   = 2'd1;
	localparam act_t ACT_DESTROY = 2'd2;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_WRITE,
		ST_SELF,
		ST_SELFW,
		ST_NBR,
		ST_DONE
	} state_t;

	// face numbering: -x, +x, -y, +y, -z, +z
	localparam int NUM_FACES = 6;

	// terrain layer at reset, by height
	function automatic mat_t layer_mat(input logic [7:0] y);
		mat_t m;
		case (y)
			8'd0:    m = MAT_BEDROCK;
			8'd1:    m = MAT_STONE;
			8'd2:    m = MAT_STONE;
			8'd3:    m = MAT_DIRT;
			8'd4:    m = MAT_GRASS;
			default: m = MAT_EMPTY;
		endcase
		return m;
	endfunction

endpackage

>>> hw/rtl/voxel_grid_face_culling_store_top.sv
// Channel   Dir  Handshake              Payload
// request   in   start & !busy          action, pos_x, pos_y, pos_z
// result    out  done (one-cycle pulse)  in_range, material, face_mask
//
// One single-port cell RAM serves every lookup; each request walks it under
// a small sequencer, one access per cycle. An out-of-range request goes
// straight to done; a destroy writes the cell, then done; a query reads the
// cell and finishes if it is empty; a place writes the cell and a query of a
// solid cell goes on to read the six neighbors before done. busy drops the
// cycle after done. After reset a fill pass writes the layered terrain into
// every cell, with busy high. The receiver cannot stall; done is never held.
module voxel_grid_face_culling_store_top #(
	parameter int SIZE_X = 16,
	parameter int SIZE_Y = 16,
	parameter int SIZE_Z = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	output logic        done,
	output logic        in_range,
	output logic [2:0]  material,
	output logic [5:0]  face_mask
);

	localparam int DEPTH    = SIZE_X * SIZE_Y * SIZE_Z;
	localparam int AW       = $clog2(DEPTH);
	localparam int XW       = (SIZE_X > 1) ? $clog2(SIZE_X) : 1;
	localparam int YW       = (SIZE_Y > 1) ? $clog2(SIZE_Y) : 1;
	localparam int ZW       = (SIZE_Z > 1) ? $clog2(SIZE_Z) : 1;
	localparam int STRIDE_X = SIZE_Y * SIZE_Z;

	localparam logic [AW-1:0] STR_X = AW'(STRIDE_X);
	localparam logic [AW-1:0] STR_Y = AW'(SIZE_Z);
	localparam logic [AW-1:0] STR_Z = AW'(1);

	vgfc_pkg::state_t state_q, state_d;

	// request context
	vgfc_pkg::act_t   action_q;
	logic             ok_q;
	logic [AW-1:0]    base_q;
	logic [XW-1:0]    x_q;
	logic [YW-1:0]    y_q;
	logic [ZW-1:0]    z_q;
	vgfc_pkg::mat_t   mat_q;
	logic [5:0]       mask_q;

	// neighbor walk: cnt_q is the face being issued, rd_face_q the one returning
	logic [2:0]       cnt_q;
	logic             rd_pend_q;
	logic [2:0]       rd_face_q;

	// terrain fill counters
	logic [AW-1:0]    init_addr_q;
	logic [YW-1:0]    init_y_q;
	logic [ZW-1:0]    init_z_q;

	// RAM port
	logic             ram_we;
	logic [AW-1:0]    ram_addr;
	vgfc_pkg::mat_t   ram_wdata;
	vgfc_pkg::mat_t   ram_rdata;

	logic             accept;
	logic             req_ok;
	logic [AW-1:0]    req_base;
	logic [5:0]       edges;
	logic [AW-1:0]    stride;
	logic [AW-1:0]    nbr_addr;
	logic             init_last;

	assign accept = start && !busy;

	// range check on the raw signed coordinates
	assign req_ok = !pos_x[15] && (pos_x[14:0] < 15'(SIZE_X)) &&
	                !pos_y[15] && (pos_y[14:0] < 15'(SIZE_Y)) &&
	                !pos_z[15] && (pos_z[14:0] < 15'(SIZE_Z));

	// linear cell address, x major, z minor; only meaningful when in range
	assign req_base = AW'(pos_x[XW-1:0]) * STR_X +
	                  AW'(pos_y[YW-1:0]) * STR_Y +
	                  AW'(pos_z[ZW-1:0]);

	// a face on the grid boundary sees outside, which counts as empty
	assign edges[0] = (x_q == '0);
	assign edges[1] = (x_q == XW'(SIZE_X - 1));
	assign edges[2] = (y_q == '0);
	assign edges[3] = (y_q == YW'(SIZE_Y - 1));
	assign edges[4] = (z_q == '0);
	assign edges[5] = (z_q == ZW'(SIZE_Z - 1));

	// shared address adder: base plus or minus the axis stride
	always_comb begin
		case (cnt_q[2:1])
			2'd0:    stride = STR_X;
			2'd1:    stride = STR_Y;
			default: stride = STR_Z;
		endcase
	end

	assign nbr_addr  = cnt_q[0] ? (base_q + stride) : (base_q - stride);
	assign init_last = (init_addr_q == AW'(DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vgfc_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = base_q;
		ram_wdata = vgfc_pkg::MAT_EMPTY;
		case (state_q)
			vgfc_pkg::ST_INIT: begin
				ram_we    = 1'b1;
				ram_addr  = init_addr_q;
				ram_wdata = vgfc_pkg::layer_mat(8'(init_y_q));
				if (init_last) begin
					state_d = vgfc_pkg::ST_IDLE;
				end
			end
			vgfc_pkg::ST_IDLE: begin
				if (start) begin
					if (!req_ok) begin
						state_d = vgfc_pkg::ST_DONE;
					end else if (action == vgfc_pkg::ACT_PLACE ||
					             action == vgfc_pkg::ACT_DESTROY) begin
						state_d = vgfc_pkg::ST_WRITE;
					end else begin
						state_d = vgfc_pkg::ST_SELF;
					end
				end
			end
			vgfc_pkg::ST_WRITE: begin
				ram_we    = 1'b1;
				ram_wdata = mat_q;
				state_d   = (action_q == vgfc_pkg::ACT_PLACE) ? vgfc_pkg::ST_NBR
				                                              : vgfc_pkg::ST_DONE;
			end
			vgfc_pkg::ST_SELF: begin
				state_d = vgfc_pkg::ST_SELFW;
			end
			vgfc_pkg::ST_SELFW: begin
				state_d = (ram_rdata == vgfc_pkg::MAT_EMPTY) ? vgfc_pkg::ST_DONE
				                                             : vgfc_pkg::ST_NBR;
			end
			vgfc_pkg::ST_NBR: begin
				ram_addr = nbr_addr;
				if (cnt_q == 3'(vgfc_pkg::NUM_FACES)) begin
					state_d = vgfc_pkg::ST_DONE;
				end
			end
			vgfc_pkg::ST_DONE: begin
				state_d = vgfc_pkg::ST_IDLE;
			end
			default: begin
				state_d = vgfc_pkg::ST_IDLE;
			end
		endcase
	end

	// fill counters walk z fastest, then y, matching the address order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_addr_q <= '0;
			init_y_q    <= '0;
			init_z_q    <= '0;
		end else if (state_q == vgfc_pkg::ST_INIT) begin
			init_addr_q <= init_addr_q + AW'(1);
			if (init_z_q == ZW'(SIZE_Z - 1)) begin
				init_z_q <= '0;
				init_y_q <= (init_y_q == YW'(SIZE_Y - 1)) ? '0 : init_y_q + YW'(1);
			end else begin
				init_z_q <= init_z_q + ZW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			rd_pend_q <= 1'b0;
			rd_face_q <= '0;
		end else begin
			rd_pend_q <= 1'b0;
			if (accept) begin
				cnt_q <= '0;
			end else if (state_q == vgfc_pkg::ST_NBR) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q < 3'(vgfc_pkg::NUM_FACES)) begin
					rd_pend_q <= 1'b1;
					rd_face_q <= cnt_q;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			ok_q     <= req_ok;
			base_q   <= req_base;
			x_q      <= pos_x[XW-1:0];
			y_q      <= pos_y[YW-1:0];
			z_q      <= pos_z[ZW-1:0];
			mask_q   <= '0;
			mat_q    <= (req_ok && action == vgfc_pkg::ACT_PLACE) ? vgfc_pkg::MAT_STONE
			                                                     : vgfc_pkg::MAT_EMPTY;
		end else begin
			if (state_q == vgfc_pkg::ST_SELFW) begin
				mat_q <= ram_rdata;
			end
			if (rd_pend_q) begin
				mask_q[rd_face_q] <= edges[rd_face_q] ||
				                     (ram_rdata == vgfc_pkg::MAT_EMPTY);
			end
		end
	end

	vgfc_ram #(
		.WIDTH (3),
		.DEPTH (DEPTH)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign busy      = (state_q != vgfc_pkg::ST_IDLE);
	assign done      = (state_q == vgfc_pkg::ST_DONE);
	assign in_range  = ok_q;
	assign material  = mat_q;
	assign face_mask = mask_q;

	// out-of-range transactions report nothing
	a_oor_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && !in_range |-> material == vgfc_pkg::MAT_EMPTY && face_mask == 6'd0)
		else $error("out-of-range result not empty");

	// an empty cell shows no faces
	a_empty_nomask: assert property (@(posedge clk) disable iff (!arst_n)
		done && material == vgfc_pkg::MAT_EMPTY |-> face_mask == 6'd0)
		else $error("empty cell with visible faces");

	// an accepted request holds the block busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted without going busy");

	// a place always reports stone
	a_place_stone: assert property (@(posedge clk) disable iff (!arst_n)
		done && in_range && action_q == vgfc_pkg::ACT_PLACE |->
		material == vgfc_pkg::MAT_STONE)
		else $error("place did not report stone");

endmodule

>>> hw/rtl/vgfc_ram.sv
module vgfc_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
